@@ rtl/core/fraction_arith_reduce_unit_defines.svh @@
// Assertion macros used by the controller of the fraction arithmetic unit.
`ifndef FRACTION_ARITH_REDUCE_UNIT_DEFINES_SVH
`define FRACTION_ARITH_REDUCE_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define FAR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the next cycle.
`define FAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/far_pkg.sv @@
// Package with types and constants of the fraction arithmetic unit.
package far_pkg;
  localparam int unsigned OperandWidthDefault = 32;
  localparam int unsigned ResWidth = 64;
  localparam int unsigned CntWidth = 7;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_RED = 3'd4
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture operands for the products
    logic prod2;     // register the products
    logic combine;   // form raw numerator and denominator
    logic div_start; // start a division
    logic div_step;  // one restoring-division step
    logic rem_take;  // Euclid: x <= y, y <= remainder
    logic qnum_take; // store numerator quotient, start den division
    logic qden_take; // store denominator quotient
    logic fin_zero;  // zero gcd: output raw values
    logic [1:0] div_sel; // 0 gcd remainder, 1 numerator, 2 denominator
  } far_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic y_zero;
    logic x_zero;
    logic div_done;
  } far_sts_t;

  localparam logic [1:0] DivSelRem = 2'd0;
  localparam logic [1:0] DivSelNum = 2'd1;
  localparam logic [1:0] DivSelDen = 2'd2;
endpackage

@@ rtl/core/far_if.sv @@
// Valid/ready channel interfaces of the fraction arithmetic unit.
interface far_in_if #(parameter int unsigned W = 32);
  logic         valid;
  logic         ready;
  logic [2:0]   action;
  logic [W-1:0] a_num;
  logic [W-1:0] a_den;
  logic [W-1:0] b_num;
  logic [W-1:0] b_den;
  modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface far_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] res_num;
  logic [63:0] res_den;
  logic        zero_gcd;
  modport source (output valid, res_num, res_den, zero_gcd, input ready);
  modport sink (input valid, res_num, res_den, zero_gcd, output ready);
endinterface

@@ rtl/core/far_datapath.sv @@
// Datapath: products, shared 64-bit restoring divider, Euclid registers, result.
module far_datapath import far_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDefault
) (
  input  logic                     clk,
  input  logic [2:0]               action,
  input  logic [OPERAND_WIDTH-1:0] a_num,
  input  logic [OPERAND_WIDTH-1:0] a_den,
  input  logic [OPERAND_WIDTH-1:0] b_num,
  input  logic [OPERAND_WIDTH-1:0] b_den,
  input  far_cmd_t                 cmd,
  output far_sts_t                 sts,
  output logic [ResWidth-1:0]      res_num,
  output logic [ResWidth-1:0]      res_den,
  output logic                     zero_gcd
);
  logic [2:0] act_r;
  logic signed [OPERAND_WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [ResWidth-1:0] p0_r, p1_r, p2_r;
  logic signed [ResWidth-1:0] num_r, den_r, x_r, y_r;
  logic [ResWidth-1:0] rem_r, quo_r, dvs_r;
  logic [CntWidth-1:0] cnt_r;
  logic neg_q_r, neg_r_r;
  logic [ResWidth-1:0] qn_hold_r;
  logic [ResWidth-1:0] qn_r, qd_r;
  logic zg_r;
  logic signed [OPERAND_WIDTH-1:0] m1a, m1b, m2a, m2b;
  logic signed [2*OPERAND_WIDTH-1:0] prod0, prod1, prod2;
  logic signed [ResWidth-1:0] dvd, dvr;
  logic [ResWidth-1:0] mag_n, mag_d, trial_rem;
  logic [ResWidth:0] trial;
  logic [ResWidth-1:0] rem_signed, quo_signed;

  // Three operand-width products per cycle; divide uses b_num for the denominator.
  always_comb begin
    m1a = an_r;
    m1b = (act_r == ACT_MUL) ? bn_r : bd_r;
    m2a = bn_r;
    m2b = ad_r;
    if (act_r == ACT_DIV) begin
      m2a = ad_r;
      m2b = bn_r;
    end
    prod0 = m1a * m1b;
    prod1 = m2a * m2b;
    prod2 = ad_r * bd_r;
  end

  // Divider operand selection.
  always_comb begin
    case (cmd.div_sel)
      DivSelRem: begin
        dvd = x_r;
        dvr = y_r;
      end
      DivSelNum: begin
        dvd = num_r;
        dvr = x_r;
      end
      DivSelDen: begin
        dvd = den_r;
        dvr = x_r;
      end
      default: begin
        dvd = x_r;
        dvr = y_r;
      end
    endcase
    mag_n = dvd[ResWidth-1] ? ResWidth'(-dvd) : dvd;
    mag_d = dvr[ResWidth-1] ? ResWidth'(-dvr) : dvr;
  end

  // One restoring step: shift in the next dividend bit and compare.
  always_comb begin
    trial = {rem_r, quo_r[ResWidth-1]} - {1'b0, dvs_r};
    trial_rem = {rem_r[ResWidth-2:0], quo_r[ResWidth-1]};
    rem_signed = neg_r_r ? ResWidth'(-rem_r) : rem_r;
    quo_signed = neg_q_r ? ResWidth'(-quo_r) : quo_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action;
      an_r <= signed'(a_num);
      ad_r <= signed'(a_den);
      bn_r <= signed'(b_num);
      bd_r <= signed'(b_den);
    end
    if (cmd.prod2) begin
      p0_r <= ResWidth'(prod0);
      p1_r <= ResWidth'(prod1);
      p2_r <= ResWidth'(prod2);
    end
    if (cmd.combine) begin
      case (act_r)
        ACT_ADD: begin
          num_r <= p0_r + p1_r;
          den_r <= p2_r;
          x_r <= p0_r + p1_r;
          y_r <= p2_r;
        end
        ACT_SUB: begin
          num_r <= p0_r - p1_r;
          den_r <= p2_r;
          x_r <= p0_r - p1_r;
          y_r <= p2_r;
        end
        ACT_MUL: begin
          num_r <= p0_r;
          den_r <= p2_r;
          x_r <= p0_r;
          y_r <= p2_r;
        end
        ACT_DIV: begin
          num_r <= p0_r;
          den_r <= p1_r;
          x_r <= p0_r;
          y_r <= p1_r;
        end
        default: begin
          num_r <= ResWidth'(an_r);
          den_r <= ResWidth'(ad_r);
          x_r <= ResWidth'(an_r);
          y_r <= ResWidth'(ad_r);
        end
      endcase
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= mag_n;
      dvs_r <= mag_d;
      cnt_r <= '0;
      neg_r_r <= dvd[ResWidth-1];
      neg_q_r <= dvd[ResWidth-1] ^ dvr[ResWidth-1];
    end else if (cmd.div_step) begin
      if (!trial[ResWidth]) begin
        rem_r <= trial[ResWidth-1:0];
        quo_r <= {quo_r[ResWidth-2:0], 1'b1};
      end else begin
        rem_r <= trial_rem;
        quo_r <= {quo_r[ResWidth-2:0], 1'b0};
      end
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.rem_take) begin
      x_r <= y_r;
      y_r <= rem_signed;
    end
    // The numerator quotient waits here so a stalled result beat stays intact.
    if (cmd.qnum_take) qn_hold_r <= quo_signed;
    if (cmd.qden_take) begin
      qn_r <= qn_hold_r;
      qd_r <= quo_signed;
      zg_r <= 1'b0;
    end
    if (cmd.fin_zero) begin
      qn_r <= num_r;
      qd_r <= den_r;
      zg_r <= 1'b1;
    end
  end

  assign sts.y_zero = (y_r == '0);
  assign sts.x_zero = (x_r == '0);
  assign sts.div_done = (cnt_r == CntWidth'(ResWidth));
  assign res_num = qn_r;
  assign res_den = qd_r;
  assign zero_gcd = zg_r;
endmodule

@@ rtl/core/far_ctrl.sv @@
// Controller state machine sequencing products, Euclid loop and divisions.
module far_ctrl import far_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  far_sts_t sts,
  output far_cmd_t cmd
);
  `include "fraction_arith_reduce_unit_defines.svh"

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_PROD  = 9'b000000010,
    ST_COMB  = 9'b000000100,
    ST_CHECK = 9'b000001000,
    ST_REM   = 9'b000010000,
    ST_QNUM  = 9'b000100000,
    ST_QDEN  = 9'b001000000,
    ST_DONE  = 9'b010000000,
    ST_ZERO  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd.prod2 = 1'b1;
        state_nxt = ST_COMB;
      end
      ST_COMB: begin
        cmd.combine = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.div_sel = DivSelRem;
        if (!sts.y_zero) begin
          cmd.div_start = 1'b1;
          state_nxt = ST_REM;
        end else if (sts.x_zero) begin
          state_nxt = ST_ZERO;
        end else begin
          cmd.div_sel = DivSelNum;
          cmd.div_start = 1'b1;
          state_nxt = ST_QNUM;
        end
      end
      ST_REM: begin
        if (sts.div_done) begin
          cmd.rem_take = 1'b1;
          state_nxt = ST_CHECK;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_QNUM: begin
        if (sts.div_done) begin
          cmd.qnum_take = 1'b1;
          cmd.div_sel = DivSelDen;
          cmd.div_start = 1'b1;
          state_nxt = ST_QDEN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_QDEN: begin
        if (sts.div_done) begin
          if (!out_valid_r || out_ready) begin
            cmd.qden_take = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_ZERO: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin_zero = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  `FAR_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")
  `FAR_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, state_r == ST_PROD,
                   "accepted beat did not start work")
  `FAR_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1,
                  $onehot0({cmd.div_step, cmd.div_start && !cmd.qnum_take, cmd.rem_take}),
                  "divider commands collide")
  `FAR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
                   "result beat dropped while stalled")
endmodule

@@ rtl/core/fraction_arith_reduce_unit.sv @@
// Top level of the fraction arithmetic unit with gcd reduction.
//   Channel | Dir | Payload
//   in_     | in  | action, a_num, a_den, b_num, b_den
//   out_    | out | res_num, res_den, zero_gcd
// An item is loaded, its products are registered and combined; then each Euclid remainder
// takes a check, 64 divider steps and an update on the shared bit-serial 64-bit divider.
// The last check and the two final divisions follow. The number of Euclid iterations depends
// on the operands. Reset is synchronous and active low; it returns the controller to idle.
// A stalled result holds in its register; the next item is taken but its result waits.
module fraction_arith_reduce_unit import far_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDefault
) (
  input logic clk,
  input logic rst_n,
  far_in_if.sink    in_ch,
  far_out_if.source out_ch
);
  far_cmd_t cmd;
  far_sts_t sts;

  far_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  far_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk      (clk),
    .action   (in_ch.action),
    .a_num    (in_ch.a_num[OPERAND_WIDTH-1:0]),
    .a_den    (in_ch.a_den[OPERAND_WIDTH-1:0]),
    .b_num    (in_ch.b_num[OPERAND_WIDTH-1:0]),
    .b_den    (in_ch.b_den[OPERAND_WIDTH-1:0]),
    .cmd      (cmd),
    .sts      (sts),
    .res_num  (out_ch.res_num),
    .res_den  (out_ch.res_den),
    .zero_gcd (out_ch.zero_gcd)
  );
endmodule

@@ tb/tb_fraction_arith_reduce_unit.sv @@
// Testbench for the fraction arithmetic unit: random and directed beats checked against a predictor.
`timescale 1ns / 1ps

module tb_fraction_arith_reduce_unit;
  import far_pkg::*;

  localparam int unsigned OpW = 32;
  localparam int unsigned IdleLimit = 60000;
  localparam int unsigned DrainCycles = 400;

  typedef struct {
    logic [2:0]     action;
    logic [OpW-1:0] a_num;
    logic [OpW-1:0] a_den;
    logic [OpW-1:0] b_num;
    logic [OpW-1:0] b_den;
  } frac_op_t;

  typedef struct {
    logic [63:0] res_num;
    logic [63:0] res_den;
    logic        zero_gcd;
  } frac_res_t;

  logic clk;
  logic rst_n;
  far_in_if #(.W(OpW)) in_ch ();
  far_out_if out_ch ();

  fraction_arith_reduce_unit #(.OPERAND_WIDTH(OpW)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  frac_op_t  pending_ops[$];
  frac_res_t expected_fracs[$];
  int        fail_count;
  int        results_seen;
  bit        in_took;
  int        send_gap;
  int        recv_gap;
  int        hold_left;
  bit        hold_done;
  int        idle_cycles;

  // Clock with a 4 ns period; it starts low so reset is set before the first rising edge.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [63:0] sext_op(logic [OpW-1:0] x);
    return {{(64-OpW){x[OpW-1]}}, x};
  endfunction

  function automatic logic [63:0] mag64(logic [63:0] x);
    return x[63] ? 64'd0 - x : x;
  endfunction

  // Truncating remainder; its sign follows the dividend.
  function automatic logic [63:0] trunc_rem(logic [63:0] n, logic [63:0] d);
    logic [63:0] r;
    r = mag64(n) % mag64(d);
    return n[63] ? 64'd0 - r : r;
  endfunction

  // Truncating quotient, wrapping for the most negative value over minus one.
  function automatic logic [63:0] trunc_quo(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    q = mag64(n) / mag64(d);
    return (n[63] != d[63]) ? 64'd0 - q : q;
  endfunction

  function automatic frac_res_t reduce_fraction(frac_op_t op);
    logic [63:0] an, ad, bn, bd, num, den, x, y, t;
    frac_res_t   r;
    an = sext_op(op.a_num);
    ad = sext_op(op.a_den);
    bn = sext_op(op.b_num);
    bd = sext_op(op.b_den);
    case (op.action)
      ACT_ADD: begin
        num = an * bd + bn * ad;
        den = ad * bd;
      end
      ACT_SUB: begin
        num = an * bd - bn * ad;
        den = ad * bd;
      end
      ACT_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      ACT_DIV: begin
        num = an * bd;
        den = ad * bn;
      end
      default: begin
        num = an;
        den = ad;
      end
    endcase
    // Euclid's loop on signed values; the gcd may come out negative.
    x = num;
    y = den;
    while (y != 64'd0) begin
      t = trunc_rem(x, y);
      x = y;
      y = t;
    end
    if (x == 64'd0) begin
      r.res_num = num;
      r.res_den = den;
      r.zero_gcd = 1'b1;
    end else begin
      r.res_num = trunc_quo(num, x);
      r.res_den = trunc_quo(den, x);
      r.zero_gcd = 1'b0;
    end
    return r;
  endfunction

  // Operands are mostly small so Euclid stays short, with extremes and full-range words mixed in.
  function automatic logic [OpW-1:0] pick_operand();
    logic [OpW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = OpW'($urandom_range(0, 60)) - OpW'(30);
      4: begin
        case ($urandom_range(0, 4))
          0: v = {1'b1, {(OpW-1){1'b0}}};
          1: v = {1'b0, {(OpW-1){1'b1}}};
          2: v = '1;
          3: v = '0;
          default: v = OpW'(1);
        endcase
      end
      5, 6: v = OpW'($urandom_range(0, 5000)) - OpW'(2500);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic int pick_gap();
    int g;
    g = $urandom_range(0, 99);
    if (g < 55) return 0;
    if (g < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic queue_op(logic [2:0] act, logic [OpW-1:0] an, logic [OpW-1:0] ad,
                          logic [OpW-1:0] bn, logic [OpW-1:0] bd);
    frac_op_t op;
    op.action = act;
    op.a_num = an;
    op.a_den = ad;
    op.b_num = bn;
    op.b_den = bd;
    pending_ops.push_back(op);
  endtask

  // Sender side: after a beat is taken, a random gap passes before the next beat is offered at a falling edge.
  always @(negedge clk) begin
    frac_op_t op;
    if (rst_n && (!in_ch.valid || in_took)) begin
      if (in_took) send_gap = pick_gap();
      if (send_gap > 0 || pending_ops.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_ch.valid <= 1'b0;
      end else begin
        op = pending_ops.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.action <= op.action;
        in_ch.a_num  <= op.a_num;
        in_ch.a_den  <= op.a_den;
        in_ch.b_num  <= op.b_num;
        in_ch.b_den  <= op.b_den;
      end
    end
  end

  // Receiver side: random stalls, and one long hold-off while the sender keeps offering.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // Monitor: record taken input beats and check result beats at the rising edge.
  always @(posedge clk) begin
    frac_op_t  op;
    frac_res_t want;
    in_took = 1'b0;
    if (rst_n) begin
      idle_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        in_took = 1'b1;
        idle_cycles = 0;
        op.action = in_ch.action;
        op.a_num = in_ch.a_num;
        op.a_den = in_ch.a_den;
        op.b_num = in_ch.b_num;
        op.b_den = in_ch.b_den;
        expected_fracs.push_back(reduce_fraction(op));
      end
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles = 0;
        results_seen++;
        if (expected_fracs.size() == 0) begin
          $display("%0t: unexpected result beat num=%h den=%h zero_gcd=%b", $time,
                   out_ch.res_num, out_ch.res_den, out_ch.zero_gcd);
          fail_count++;
        end else begin
          want = expected_fracs.pop_front();
          if (out_ch.res_num !== want.res_num) begin
            $display("%0t: res_num expected %h actual %h", $time, want.res_num,
                     out_ch.res_num);
            fail_count++;
          end
          if (out_ch.res_den !== want.res_den) begin
            $display("%0t: res_den expected %h actual %h", $time, want.res_den,
                     out_ch.res_den);
            fail_count++;
          end
          if (out_ch.zero_gcd !== want.zero_gcd) begin
            $display("%0t: zero_gcd expected %b actual %b", $time, want.zero_gcd,
                     out_ch.zero_gcd);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $time, IdleLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [OpW-1:0] min_v, max_v, neg1;
    int act_pick;
    min_v = {1'b1, {(OpW-1){1'b0}}};
    max_v = {1'b0, {(OpW-1){1'b1}}};
    neg1 = '1;
    fail_count = 0;
    results_seen = 0;
    in_took = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    hold_left = 0;
    hold_done = 1'b0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_ADD;
    in_ch.a_num = '0;
    in_ch.a_den = '0;
    in_ch.b_num = '0;
    in_ch.b_den = '0;
    out_ch.ready = 1'b0;

    // Directed beats: each action, extremes, and the named corner cases.
    queue_op(ACT_ADD, 1, 2, 1, 3);
    queue_op(ACT_SUB, 1, 2, 1, 3);
    queue_op(ACT_MUL, 6, -4, 10, 9);
    queue_op(ACT_DIV, 3, 4, -9, 8);
    queue_op(ACT_RED, 12, -18, 5, 7);
    queue_op(3'd5, 14, 21, 1, 1);
    queue_op(3'd6, -8, 12, 3, 3);
    queue_op(3'd7, 100, 75, 0, 0);
    queue_op(ACT_RED, 5, 9, max_v, min_v);   // B ignored on reduce
    queue_op(ACT_ADD, min_v, min_v, min_v, min_v); // cross sum wraps
    queue_op(ACT_SUB, min_v, max_v, max_v, min_v);
    queue_op(ACT_RED, 0, 0, 7, 7);           // zero gcd
    queue_op(ACT_MUL, 0, 5, 3, 0);           // zero gcd through products
    queue_op(ACT_RED, 6, 0, 0, 0);           // zero denominator
    queue_op(ACT_DIV, 4, 3, 0, 5);
    queue_op(ACT_RED, min_v, neg1, 0, 0);    // most negative over minus one
    queue_op(ACT_RED, neg1, min_v, 0, 0);
    queue_op(ACT_MUL, min_v, neg1, min_v, 1);
    queue_op(ACT_MUL, max_v, max_v, max_v, max_v);
    queue_op(ACT_ADD, max_v, 1, max_v, 1);
    queue_op(ACT_DIV, neg1, neg1, neg1, neg1);
    queue_op(ACT_RED, 55, 89, 0, 0);
    queue_op(ACT_SUB, 3, 7, 3, 7);

    // Random beats; a few carry the unused action codes.
    repeat (450) begin
      act_pick = $urandom_range(0, 15);
      queue_op((act_pick < 15) ? 3'(act_pick % 5) : 3'($urandom_range(5, 7)),
               pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all beats sent, all results back, then a quiet period.
    wait (pending_ops.size() == 0 && !in_ch.valid && expected_fracs.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
